FILE: rtl/core/homogeneous_point_transform_macros.svh
// Assertion macros shared by the point transform RTL.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that an expression holds at every clock edge outside reset.
`define HPT_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// Checks that a condition implies a consequence in the same cycle.
`define HPT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define HPT_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define HPT_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/hpt_pkg.sv
// Types and constants of the homogeneous point transform.
`timescale 1ns / 1ps
package hpt_pkg;

   localparam int NUM_REGS = 8;
   localparam int REG_W    = 64;
   localparam int IDX_W    = 3;
   localparam int COORD_W  = 32;
   localparam int PROD_W   = 64;
   // Row sums: three floored products plus a coefficient, with headroom.
   localparam int SUM_W    = 51;
   localparam int QUO_W    = 32;

   localparam logic [REG_W-1:0] RESET_ROW01_0 = 64'h0000_0000_0001_0000;
   localparam logic [REG_W-1:0] RESET_ROW01_1 = 64'h0001_0000_0000_0000;
   localparam logic [REG_W-1:0] RESET_ZERO    = 64'h0;

   localparam logic signed [SUM_W-1:0] ONE_Q16 = 51'sd65536;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      divided;
      logic                      saturated;
   } rsp_type;

   typedef logic [NUM_REGS-1:0][REG_W-1:0] matrix_type;

   // One result coordinate after saturation.
   typedef struct packed {
      logic [COORD_W-1:0] value;
      logic               sat;
   } clamp_type;

   // Clamp a sign and magnitude to the signed 32-bit range.
   function automatic clamp_type clamp_coord(input logic neg, input logic [SUM_W-1:0] mag);
      clamp_type res;
      logic [SUM_W-1:0] neg_mag;
      neg_mag = -mag;
      res.sat = 1'b0;
      if (neg) begin
         if (mag > 51'h8000_0000) begin
            res.sat   = 1'b1;
            res.value = 32'h8000_0000;
         end else begin
            res.value = neg_mag[COORD_W-1:0];
         end
      end else begin
         if (mag > 51'h7FFF_FFFF) begin
            res.sat   = 1'b1;
            res.value = 32'h7FFF_FFFF;
         end else begin
            res.value = mag[COORD_W-1:0];
         end
      end
      return res;
   endfunction

endpackage

FILE: rtl/core/hpt_mac.sv
// Matrix times point: a product stage and a row summing stage.
`timescale 1ns / 1ps
module hpt_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  logic                               in_valid,
   input  hpt_pkg::req_type                   in_data,
   input  hpt_pkg::matrix_type                coef,
   output logic                               out_valid,
   output logic signed [3:0][hpt_pkg::SUM_W-1:0] out_sum
);
   import hpt_pkg::*;

   logic signed [3:0][2:0][PROD_W-1:0] prod_ff, prod_in;
   logic signed [3:0][COORD_W-1:0]     trans_ff, trans_in;
   logic signed [3:0][SUM_W-1:0]       sum_ff, sum_in;
   logic                               prod_valid_ff, sum_valid_ff;
   logic signed [2:0][COORD_W-1:0]     pt;

   assign pt[0] = in_data.point_x;
   assign pt[1] = in_data.point_y;
   assign pt[2] = in_data.point_z;

   // Twelve independent products, one per coefficient of the first three columns.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         prod_in[r][0] = $signed(coef[2*r][31:0]) * $signed(pt[0]);
         prod_in[r][1] = $signed(coef[2*r][63:32]) * $signed(pt[1]);
         prod_in[r][2] = $signed(coef[2*r+1][31:0]) * $signed(pt[2]);
         trans_in[r]   = $signed(coef[2*r+1][63:32]);
      end
   end

   // Floor each product to Q16.16 and add the translation column.
   // Elements of a packed array read as unsigned, so the sign is restored first.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sum_in[r] = SUM_W'($signed(prod_ff[r][0]) >>> 16)
                   + SUM_W'($signed(prod_ff[r][1]) >>> 16)
                   + SUM_W'($signed(prod_ff[r][2]) >>> 16)
                   + SUM_W'($signed(trans_ff[r]));
      end
   end

   // Stage registers, advanced together under the shared enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else if (enable) begin
         prod_valid_ff <= in_valid;
         sum_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff  <= prod_in;
         trans_ff <= trans_in;
         sum_ff   <= sum_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_sum   = sum_ff;
endmodule

FILE: rtl/core/hpt_div_lane.sv
// One coordinate lane: sign and magnitude setup, then one quotient bit per stage.
`timescale 1ns / 1ps
module hpt_div_lane (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  logic                            in_valid,
   input  logic                            div_en,
   input  logic signed [hpt_pkg::SUM_W-1:0] numer,
   input  logic signed [hpt_pkg::SUM_W-1:0] denom,
   output logic                            out_valid,
   output logic                            out_neg,
   output logic [hpt_pkg::SUM_W-1:0]       out_mag
);
   import hpt_pkg::*;

   typedef struct packed {
      logic [SUM_W-1:0] rem;
      logic [QUO_W-1:0] nlow;
      logic [QUO_W-1:0] quo;
      logic [SUM_W-1:0] den;
      logic             neg;
      logic             ovf;
      logic             div_en;
      logic [SUM_W-1:0] pmag;
   } stage_type;

   stage_type        stage_ff [QUO_W+1];
   stage_type        stage_in [QUO_W+1];
   logic [QUO_W:0]   valid_ff;
   logic [SUM_W-1:0] un, ud;
   logic [SUM_W-1:0] neg_n, neg_d;

   assign neg_n = -numer;
   assign neg_d = -denom;
   assign un = numer[SUM_W-1] ? neg_n : numer;
   assign ud = denom[SUM_W-1] ? neg_d : denom;

   // Setup (magnitudes, sign, overflow test, first partial remainder),
   // then the restoring division steps, one quotient bit each.
   always_comb begin
      logic [SUM_W:0] r2;
      logic           ge;
      stage_in[0].rem    = SUM_W'(un[SUM_W-1:16]);
      stage_in[0].nlow   = {un[15:0], 16'h0};
      stage_in[0].quo    = '0;
      stage_in[0].den    = ud;
      stage_in[0].div_en = div_en;
      stage_in[0].pmag   = un;
      stage_in[0].ovf    = ({16'h0, un} >= {ud, 16'h0});
      stage_in[0].neg    = div_en ? (numer[SUM_W-1] ^ denom[SUM_W-1]) : numer[SUM_W-1];
      for (int k = 0; k < QUO_W; k++) begin
         r2 = {stage_ff[k].rem, stage_ff[k].nlow[QUO_W-1]};
         ge = (r2 >= {1'b0, stage_ff[k].den});
         stage_in[k+1]      = stage_ff[k];
         stage_in[k+1].rem  = ge ? SUM_W'(r2 - {1'b0, stage_ff[k].den}) : r2[SUM_W-1:0];
         stage_in[k+1].nlow = {stage_ff[k].nlow[QUO_W-2:0], 1'b0};
         stage_in[k+1].quo  = {stage_ff[k].quo[QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[QUO_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k <= QUO_W; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // An overflowed quotient is reported as 2^32, which always saturates.
   always_comb begin
      if (!stage_ff[QUO_W].div_en) begin
         out_mag = stage_ff[QUO_W].pmag;
      end else if (stage_ff[QUO_W].ovf) begin
         out_mag = SUM_W'(64'h1_0000_0000);
      end else begin
         out_mag = SUM_W'(stage_ff[QUO_W].quo);
      end
   end

   assign out_neg   = stage_ff[QUO_W].neg;
   assign out_valid = valid_ff[QUO_W];
endmodule

FILE: rtl/core/homogeneous_point_transform.sv
// Top level: configuration registers, datapath stages and the output register.
//
//   Channel  Ports      Payload
//   input    req_*      point_x, point_y, point_z (Q16.16)
//   result   rsp_*      out_x, out_y, out_z, divided, saturated
//   config   csr_*      eight 64-bit matrix registers, write only
//
// One point per cycle unless a held result is stalled. Stages: product, row sum,
// divider setup, 32 quotient-bit stages, output register; the lanes set the depth.
// Reset clears all valid bits and loads the identity matrix.
// A stalled result freezes the whole pipeline, so req_stall follows rsp_stall
// while a result is held; nothing is dropped or repeated.
`timescale 1ns / 1ps
module homogeneous_point_transform (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  hpt_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output hpt_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [hpt_pkg::IDX_W-1:0]           csr_index,
   input  logic [hpt_pkg::REG_W-1:0]           csr_wdata
);
   import hpt_pkg::*;
`include "homogeneous_point_transform_macros.svh"

   matrix_type                 coef_ff;
   logic                       enable;
   logic                       mac_valid;
   logic signed [3:0][SUM_W-1:0] sums;
   logic                       div_en;
   logic [2:0]                 lane_valid, lane_neg;
   logic [2:0][SUM_W-1:0]      lane_mag;
   logic [2:0]                 div_en_pipe_dummy;
   logic [QUO_W:0]             divided_ff;
   clamp_type [2:0]            clamp;
   rsp_type                    rsp_in, rsp_ff;
   logic                       rsp_valid_ff;

   // The pipeline advances unless a held result is stalled.
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   // Matrix register writes; reset loads the identity matrix.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= {RESET_ROW01_1, RESET_ZERO, RESET_ROW01_0, RESET_ZERO,
                     RESET_ZERO, RESET_ROW01_1, RESET_ZERO, RESET_ROW01_0};
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   hpt_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .coef      (coef_ff),
      .out_valid (mac_valid),
      .out_sum   (sums)
   );

   // Divide only when w is neither zero nor exactly one.
   assign div_en = (sums[3] != '0) && (sums[3] != ONE_Q16);

   for (genvar i = 0; i < 3; i++) begin : g_lane
      hpt_div_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (mac_valid),
         .div_en    (div_en),
         .numer     (sums[i]),
         .denom     (sums[3]),
         .out_valid (lane_valid[i]),
         .out_neg   (lane_neg[i]),
         .out_mag   (lane_mag[i])
      );
      assign clamp[i] = clamp_coord(lane_neg[i], lane_mag[i]);
      assign div_en_pipe_dummy[i] = lane_valid[i];
   end

   // The divided flag rides alongside the lanes.
   always_ff @(posedge clock) begin
      if (enable) begin
         divided_ff <= {divided_ff[QUO_W-1:0], div_en};
      end
   end

   always_comb begin
      rsp_in.out_x     = clamp[0].value;
      rsp_in.out_y     = clamp[1].value;
      rsp_in.out_z     = clamp[2].value;
      rsp_in.divided   = divided_ff[QUO_W];
      rsp_in.saturated = clamp[0].sat | clamp[1].sat | clamp[2].sat;
   end

   // Output register; it holds while the result transfer is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= &div_en_pipe_dummy;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The input side stalls only behind a held result.
   `HPT_ASSERT_IMPLY(a_stall_only_when_held, clock, reset, req_stall, rsp_valid)
   // A saturated result carries at least one clamped coordinate.
   `HPT_ASSERT_IMPLY(a_sat_has_limit, clock, reset, rsp_valid && rsp_data.saturated,
      rsp_data.out_x == 32'h7FFF_FFFF || rsp_data.out_x == 32'h8000_0000
      || rsp_data.out_y == 32'h7FFF_FFFF || rsp_data.out_y == 32'h8000_0000
      || rsp_data.out_z == 32'h7FFF_FFFF || rsp_data.out_z == 32'h8000_0000)
   // The three lanes stay in step.
   `HPT_ASSERT_ALWAYS(a_lanes_aligned, clock, reset,
      lane_valid[0] == lane_valid[1] && lane_valid[1] == lane_valid[2])
endmodule

FILE: tb/homogeneous_point_transform_test.sv
// Testbench for the homogeneous point transform: directed and random points against a predictor.
`timescale 1ns / 1ps
module homogeneous_point_transform_test;
   import hpt_pkg::*;

   localparam int LATENCY     = 36;
   localparam int WATCH_LIMIT = 4000;

   // Register indexes of the matrix.
   typedef enum logic [IDX_W-1:0] {
      REG_ROW0_C01 = 3'd0, REG_ROW0_C23 = 3'd1, REG_ROW1_C01 = 3'd2, REG_ROW1_C23 = 3'd3,
      REG_ROW2_C01 = 3'd4, REG_ROW2_C23 = 3'd5, REG_ROW3_C01 = 3'd6, REG_ROW3_C23 = 3'd7
   } reg_index_type;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;
   logic csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [REG_W-1:0] csr_wdata;

   logic [REG_W-1:0] matrix [NUM_REGS];
   req_type pending_points [$];
   rsp_type expected_points [$];
   int error_count = 0;
   int idle_watch = 0;
   bit quiet_phase = 0;
   bit req_taken = 0;

   homogeneous_point_transform DUT (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Fetch one signed Q16.16 coefficient.
   function automatic longint coef(int row, int col);
      logic [REG_W-1:0] r;
      r = matrix[row*2 + col/2];
      return (col % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
   endfunction

   function automatic longint floor_q16(longint p);
      return p >>> 16;
   endfunction

   function automatic longint transform_row(int row, longint x, longint y, longint z);
      return floor_q16(coef(row, 0) * x) + floor_q16(coef(row, 1) * y)
           + floor_q16(coef(row, 2) * z) + coef(row, 3);
   endfunction

   // Clamp a sign and magnitude to 32 bits.
   function automatic logic [31:0] clamp32(bit neg, longint unsigned mag, ref bit sat);
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            sat = 1;
            return 32'h8000_0000;
         end
         return 32'(-mag);
      end
      if (mag > 64'h7FFF_FFFF) begin
         sat = 1;
         return 32'h7FFF_FFFF;
      end
      return 32'(mag);
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   // Perspective divide (n * 2^16) / d, truncated toward zero.
   function automatic logic [31:0] divide_q16(longint n, longint d, ref bit sat);
      longint unsigned un, ud, q;
      bit neg;
      un = magnitude(n);
      ud = magnitude(d);
      neg = (n < 0) != (d < 0);
      q = un / ud;
      if (q > 64'h8000) return clamp32(neg, 64'h1_0000_0000, sat);
      q = (un << 16) / ud;
      return clamp32(neg && q != 0, q, sat);
   endfunction

   function automatic rsp_type transform_point(req_type p);
      rsp_type r;
      longint v [3];
      longint w;
      bit sat, div;
      logic [31:0] res [3];
      sat = 0;
      for (int i = 0; i < 3; i++)
         v[i] = transform_row(i, p.point_x, p.point_y, p.point_z);
      w = transform_row(3, p.point_x, p.point_y, p.point_z);
      div = (w != 0) && (w != 65536);
      for (int i = 0; i < 3; i++)
         res[i] = div ? divide_q16(v[i], w, sat) : clamp32(v[i] < 0, magnitude(v[i]), sat);
      r.out_x = res[0];
      r.out_y = res[1];
      r.out_z = res[2];
      r.divided = div;
      r.saturated = sat;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("Mismatch in %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   // Driver: a new transfer is offered once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_taken) begin
         if (pending_points.size() > 0 && (quiet_phase || $urandom_range(99) >= 12)) begin
            req_data  <= pending_points.pop_front();
            req_valid <= 1;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // Receiver stall.
   always @(negedge clock) begin
      rsp_stall <= reset ? 1'b0 : (!quiet_phase && $urandom_range(99) < 12);
   end

   // Monitor, prediction and watchdog.
   always @(posedge clock) begin
      rsp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_points.push_back(transform_point(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               report_mismatch("unexpected result", longint'(rsp_data.out_x), 0);
            end else begin
               want = expected_points.pop_front();
               if (rsp_data.out_x !== want.out_x)
                  report_mismatch("out_x", rsp_data.out_x, want.out_x);
               if (rsp_data.out_y !== want.out_y)
                  report_mismatch("out_y", rsp_data.out_y, want.out_y);
               if (rsp_data.out_z !== want.out_z)
                  report_mismatch("out_z", rsp_data.out_z, want.out_z);
               if (rsp_data.divided !== want.divided)
                  report_mismatch("divided", rsp_data.divided, want.divided);
               if (rsp_data.saturated !== want.saturated)
                  report_mismatch("saturated", rsp_data.saturated, want.saturated);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_watch <= 0;
         else idle_watch <= idle_watch + 1;
         if (idle_watch >= WATCH_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic write_reg(reg_index_type idx, logic [REG_W-1:0] value);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx < NUM_REGS) matrix[idx] = value;
      @(negedge clock);
      csr_we <= 0;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(65536 * 4) - 65536 * 2;
         3: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type rand_point();
      req_type p;
      p.point_x = rand_coord();
      p.point_y = rand_coord();
      p.point_z = rand_coord();
      return p;
   endfunction

   // Wait until every point is sent and every result is back, then idle a little.
   task automatic drain();
      do
         @(posedge clock);
      while (pending_points.size() != 0 || req_valid || expected_points.size() != 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic load_matrix(int style);
      for (int i = 0; i < NUM_REGS; i++) begin
         case (style)
            0: write_reg(reg_index_type'(i), (i == 0 || i == 5) ? 64'h1_0000 :
                         (i == 2 || i == 7) ? 64'h1_0000_0000_0000 : 64'h0);
            1: write_reg(reg_index_type'(i), {$urandom_range(131072) - 65536,
                                               $urandom_range(131072) - 65536});
            2: write_reg(reg_index_type'(i), {$urandom, $urandom});
            3: write_reg(reg_index_type'(i), (i % 2) ? 64'h7FFF_FFFF_8000_0000
                                                     : 64'h8000_0000_7FFF_FFFF);
            default: write_reg(reg_index_type'(i), {$urandom_range(8) << 14,
                                                    $urandom_range(131072) - 65536});
         endcase
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      rsp_stall = 0;
      req_data = '0;
      csr_we = 0;
      csr_index = REG_ROW0_C01;
      csr_wdata = '0;
      matrix[0] = RESET_ROW01_0; matrix[1] = RESET_ZERO;
      matrix[2] = RESET_ROW01_1; matrix[3] = RESET_ZERO;
      matrix[4] = RESET_ZERO;    matrix[5] = RESET_ROW01_0;
      matrix[6] = RESET_ZERO;    matrix[7] = RESET_ROW01_1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: identity extremes, then w of zero, one and other values.
      pending_points.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0});
      pending_points.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF});
      pending_points.push_back('{32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001});
      drain();
      // w depends on x: x=0 gives w zero, x=1.0 gives w one, else divide.
      write_reg(REG_ROW3_C01, 64'h0000_0000_0001_0000);
      write_reg(REG_ROW3_C23, 64'h0);
      pending_points.push_back('{32'h0, 32'h7FFF_FFFF, 32'h8000_0000});
      pending_points.push_back('{32'h0001_0000, 32'h1234_5678, 32'hFEDC_BA98});
      pending_points.push_back('{32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000});
      pending_points.push_back('{32'hFFFF_FFFF, 32'h0001_0000, 32'h0});
      pending_points.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
      pending_points.push_back('{32'h7FFF_FFFF, 32'h0, 32'h0002_0000});
      pending_points.push_back('{32'hFFFF_0000, 32'h0003_0000, 32'hFFFD_0000});
      drain();
      // Extreme coefficients everywhere, saturation in both directions.
      load_matrix(3);
      for (int i = 0; i < 6; i++) pending_points.push_back(rand_point());
      drain();

      // Random phases over several matrices; the first runs without idling.
      for (int phase = 0; phase < 12; phase++) begin
         quiet_phase = (phase == 0);
         load_matrix(phase % 5);
         for (int i = 0; i < 150; i++) pending_points.push_back(rand_point());
         drain();
      end
      quiet_phase = 0;
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
